[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("quadrature counter assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define QC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("quadrature counter assertion failed");

`endif

[hw/rtl/qcsw_pkg.sv]
// ----------------------------------------------------------------------------
// Quadrature counter package
// Widths, event codes, shared types and the output conversion function.
// ----------------------------------------------------------------------------
`default_nettype none

package qcsw_pkg;

    // Width of the position, snapshot and speed counters.
    localparam int COUNT_WIDTH = 32;
    // Width of the result ports.
    localparam int OUT_WIDTH   = 32;
    // Window register and tick counter widths.
    localparam int WIN_WIDTH   = 10;
    localparam int TICK_WIDTH  = 11;

    localparam logic [WIN_WIDTH-1:0] WIN_RESET = WIN_WIDTH'(50);

    // Event codes carried by the operation field.
    typedef enum logic [1:0] {
        OP_EDGE_A = 2'd0,
        OP_EDGE_B = 2'd1,
        OP_TICK   = 2'd2
    } t_op;

    // One accepted event handed to the counter core.
    typedef struct packed {
        logic       go;
        logic [1:0] op;
        logic       level_a;
        logic       level_b;
    } t_evt;

    // One result as it leaves the counter core.
    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] position;
        logic signed [OUT_WIDTH-1:0] speed;
        logic                        speed_updated;
    } t_res;

    // Sign-extend a count to the port width, then keep the low port bits.
    function automatic logic signed [OUT_WIDTH-1:0] f_to_out(
        input logic [COUNT_WIDTH-1:0] v
    );
        logic [COUNT_WIDTH+OUT_WIDTH-1:0] ext;
        ext = {{OUT_WIDTH{v[COUNT_WIDTH-1]}}, v};
        return signed'(ext[OUT_WIDTH-1:0]);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/qcsw_core.sv]
// ----------------------------------------------------------------------------
// Quadrature counter core
// Position, window snapshot, tick counter and speed state with the result
// register. One event is applied per cycle when the event's go bit is set.
// ----------------------------------------------------------------------------
`default_nettype none

module qcsw_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic [qcsw_pkg::WIN_WIDTH-1:0]       i_window,
    input  wire qcsw_pkg::t_evt                       i_evt,
    output qcsw_pkg::t_res                            o_res
);

    logic [qcsw_pkg::COUNT_WIDTH-1:0] r_pos;
    logic [qcsw_pkg::COUNT_WIDTH-1:0] r_start;
    logic [qcsw_pkg::COUNT_WIDTH-1:0] r_speed;
    logic [qcsw_pkg::TICK_WIDTH-1:0]  r_tick;
    qcsw_pkg::t_res                   r_res;

    logic [qcsw_pkg::COUNT_WIDTH-1:0] n_pos;
    logic [qcsw_pkg::COUNT_WIDTH-1:0] n_start;
    logic [qcsw_pkg::COUNT_WIDTH-1:0] n_speed;
    logic [qcsw_pkg::TICK_WIDTH-1:0]  n_tick;
    logic                             n_updated;

    logic                             same_level;
    logic                             snap_hit;
    logic                             win_hit;
    logic [qcsw_pkg::TICK_WIDTH-1:0]  win_end;

    // Tick count at which the window closes.
    assign win_end    = qcsw_pkg::TICK_WIDTH'({1'b0, i_window}) + qcsw_pkg::TICK_WIDTH'(1);
    assign snap_hit   = (r_tick == qcsw_pkg::TICK_WIDTH'(1));
    assign win_hit    = (r_tick == win_end);
    assign same_level = (i_evt.level_a == i_evt.level_b);

    // Next state for one event; an unused code leaves everything unchanged.
    always_comb begin
        n_pos     = r_pos;
        n_start   = r_start;
        n_speed   = r_speed;
        n_tick    = r_tick;
        n_updated = 1'b0;
        case (qcsw_pkg::t_op'(i_evt.op))
            qcsw_pkg::OP_EDGE_A: begin
                n_pos = same_level ? r_pos + qcsw_pkg::COUNT_WIDTH'(1)
                                   : r_pos - qcsw_pkg::COUNT_WIDTH'(1);
            end
            qcsw_pkg::OP_EDGE_B: begin
                n_pos = same_level ? r_pos - qcsw_pkg::COUNT_WIDTH'(1)
                                   : r_pos + qcsw_pkg::COUNT_WIDTH'(1);
            end
            qcsw_pkg::OP_TICK: begin
                // The snapshot is taken first, so a zero window measures zero.
                if (snap_hit) begin
                    n_start = r_pos;
                end
                if (win_hit) begin
                    n_speed   = r_pos - n_start;
                    n_updated = 1'b1;
                    n_tick    = qcsw_pkg::TICK_WIDTH'(1);
                end else begin
                    n_tick = r_tick + qcsw_pkg::TICK_WIDTH'(1);
                end
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    // Counter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_start <= '0;
            r_speed <= '0;
            r_tick  <= '0;
        end else if (i_evt.go) begin
            r_pos   <= n_pos;
            r_start <= n_start;
            r_speed <= n_speed;
            r_tick  <= n_tick;
        end
    end

    // Result register, loaded together with the state.
    always_ff @(posedge i_clk) begin
        if (i_evt.go) begin
            r_res.position      <= qcsw_pkg::f_to_out(n_pos);
            r_res.speed         <= qcsw_pkg::f_to_out(n_speed);
            r_res.speed_updated <= n_updated;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

[hw/rtl/quadrature_counter_with_speed_window.sv]
// ----------------------------------------------------------------------------
// Quadrature counter with speed window
// x4 quadrature decoder with a signed position count and a speed value
// measured as the count difference over a programmable number of ticks.
// ----------------------------------------------------------------------------
// Each request is one event (A edge, B edge or timer tick) and returns exactly
// one result holding the position after the event, the last measured speed
// and a flag set on the tick that closed a window. The block takes one event
// per clock cycle while the result side does not stall; an event is held in the
// input register and its result in the result register, and the single add or
// subtract of the counter core between them sets the cycle time. The window
// register may only be written while no event is in flight; its write channel
// is always ready. Position and speed wrap modulo 2^32.
`default_nettype none

module quadrature_counter_with_speed_window (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Event request channel.
    input  wire logic                                 i_in_valid,
    output      logic                                 o_in_stall,
    input  wire logic [1:0]                           i_operation,
    input  wire logic                                 i_level_a,
    input  wire logic                                 i_level_b,
    // Result request channel.
    output      logic                                 o_out_valid,
    input  wire logic                                 i_out_stall,
    output      logic signed [qcsw_pkg::OUT_WIDTH-1:0] o_position,
    output      logic signed [qcsw_pkg::OUT_WIDTH-1:0] o_speed,
    output      logic                                 o_speed_updated,
    // Window register write channel.
    input  wire logic                                 i_cfg_valid,
    output      logic                                 o_cfg_ready,
    input  wire logic [qcsw_pkg::WIN_WIDTH-1:0]       i_cfg_data
);

    logic                             r_in_vld;
    logic [1:0]                       r_op;
    logic                             r_level_a;
    logic                             r_level_b;
    logic                             r_out_vld;
    logic [qcsw_pkg::WIN_WIDTH-1:0]   r_window;

    logic                             in_take;
    logic                             out_free;
    logic                             step_go;
    qcsw_pkg::t_evt                   evt;
    qcsw_pkg::t_res                   res;

    // Handshake: the result slot frees when empty or when taken this cycle.
    assign out_free   = !r_out_vld || !i_out_stall;
    assign step_go    = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (step_go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op      <= i_operation;
            r_level_a <= i_level_a;
            r_level_b <= i_level_b;
        end
    end

    // Result valid follows the core's result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step_go) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // Window register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= qcsw_pkg::WIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window <= i_cfg_data;
        end
    end

    // Counter core.
    assign evt.go      = step_go;
    assign evt.op      = r_op;
    assign evt.level_a = r_level_a;
    assign evt.level_b = r_level_b;

    qcsw_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_window (r_window),
        .i_evt    (evt),
        .o_res    (res)
    );

    assign o_out_valid     = r_out_vld;
    assign o_position      = res.position;
    assign o_speed         = res.speed;
    assign o_speed_updated = res.speed_updated;

endmodule

`default_nettype wire

[hw/rtl/qcsw_checker.sv]
// ----------------------------------------------------------------------------
// Quadrature counter checker
// Port-level checks on the result stream of the quadrature counter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module qcsw_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 o_out_valid,
    input  wire logic                                 i_out_stall,
    input  wire logic signed [qcsw_pkg::OUT_WIDTH-1:0] o_position,
    input  wire logic signed [qcsw_pkg::OUT_WIDTH-1:0] o_speed,
    input  wire logic                                 o_speed_updated
);

    logic                                  r_seen;
    logic signed [qcsw_pkg::OUT_WIDTH-1:0] r_last_pos;
    logic signed [qcsw_pkg::OUT_WIDTH-1:0] r_last_speed;
    logic                                  out_take;
    logic signed [qcsw_pkg::OUT_WIDTH-1:0] pos_diff;

    assign out_take = o_out_valid && !i_out_stall;
    assign pos_diff = o_position - r_last_pos;

    // Remember the last delivered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (out_take) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_last_pos   <= o_position;
            r_last_speed <= o_speed;
        end
    end

    // A stalled result stays presented.
    `QC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // Each event moves the position by at most one step.
    `QC_ASSERT_IMP(a_pos_step, i_clk, i_rst_n, out_take && r_seen, pos_diff == 0 || pos_diff == 1 || pos_diff == -1)

    // Speed only changes on a result that reports an update.
    `QC_ASSERT_IMP(a_speed_hold, i_clk, i_rst_n, out_take && r_seen && !o_speed_updated, o_speed == r_last_speed)

    // A speed update comes from a tick, which leaves the position alone.
    `QC_ASSERT_IMP(a_tick_pos, i_clk, i_rst_n, out_take && r_seen && o_speed_updated, o_position == r_last_pos)

endmodule

bind quadrature_counter_with_speed_window qcsw_checker u_qcsw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_position      (o_position),
    .o_speed         (o_speed),
    .o_speed_updated (o_speed_updated)
);

`default_nettype wire
